// ----- hdl/crd_pkg.sv -----
package crd_pkg;

    localparam int CORDIC_STAGES_DEFAULT = 16;

    localparam int PT_W      = 16;
    localparam int FOV_W     = 16;
    localparam int ROW_W     = 48;
    localparam int COEF_W    = 16;
    localparam int DIR_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 2;

    localparam int SQ_W      = 52;
    localparam int SQ_STEPS  = 26;
    localparam int MAG_W     = 26;
    localparam int DIV_BITS  = 31;
    localparam int NUM_W     = 56;
    localparam int ANG_W     = 34;
    localparam int VEC_W     = 34;
    localparam int V_W       = 39;
    localparam int PROD_W    = 55;
    localparam int ACC_W     = 57;
    localparam int ACC_SHIFT = 28;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd4;

    localparam logic [MODE_W-1:0] MODE_FISHEYE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FISHEYE_CUT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EQUIRECT    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PERSPECTIVE = 2'd3;

    localparam logic [FOV_W-1:0] FOV_RESET  = 16'd4096;
    localparam logic [ROW_W-1:0] ROW0_RESET = 48'd16384;
    localparam logic [ROW_W-1:0] ROW1_RESET = 48'd1073741824;
    localparam logic [ROW_W-1:0] ROW2_RESET = 48'd70368744177664;

    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [V_W-1:0]   ONE_V       = 39'sd1073741824;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    typedef struct packed {
        logic [SQ_W-1:0]        rem;
        logic [SQ_W-1:0]        root;
        logic signed [PT_W-1:0] px;
        logic signed [PT_W-1:0] py;
    } sq_t;

    typedef struct packed {
        logic [NUM_W-1:0]        rem_x;
        logic [NUM_W-1:0]        rem_y;
        logic [DIV_BITS-1:0]     q_x;
        logic [DIV_BITS-1:0]     q_y;
        logic [MAG_W-1:0]        den;
        logic                    neg_x;
        logic                    neg_y;
        logic                    zero;
        logic signed [VEC_W-1:0] ax;
        logic signed [VEC_W-1:0] ay;
        logic signed [ANG_W-1:0] az;
        logic signed [VEC_W-1:0] bx;
        logic signed [VEC_W-1:0] by;
        logic signed [ANG_W-1:0] bz;
        logic                    flip_a;
        logic                    flip_b;
        logic signed [PT_W-1:0]  px;
        logic signed [PT_W-1:0]  py;
    } core_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/crd_sqrt_cell.sv -----
module crd_sqrt_cell
    import crd_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  sq_t  in_data,
    output logic out_valid,
    output sq_t  out_data
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

    logic [SQ_W-1:0] trial;
    sq_t             data_next;
    logic            valid_reg;
    sq_t             data_reg;

    always_comb begin
        data_next = in_data;
        trial     = in_data.root + BIT;
        if (in_data.rem >= trial) begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + BIT;
        end else begin
            data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/crd_core_cell.sv -----
module crd_core_cell
    import crd_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int STAGES = CORDIC_STAGES_DEFAULT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  core_t in_data,
    output logic  out_valid,
    output core_t out_data
);

    localparam bit DIV_ON = IDX < DIV_BITS;
    localparam int J      = DIV_ON ? DIV_BITS - 1 - IDX : 0;
    localparam bit ROT_ON = IDX < STAGES;
    localparam logic signed [ANG_W-1:0] ATAN = $signed({2'b00, atan_turn(IDX)});

    logic [NUM_W:0] trial;
    core_t          data_next;
    logic           valid_reg;
    core_t          data_reg;

    always_comb begin
        data_next = in_data;
        trial     = {{(NUM_W + 1 - MAG_W){1'b0}}, in_data.den} << J;
        if (DIV_ON) begin
            if ({1'b0, in_data.rem_x} >= trial) begin
                data_next.rem_x  = in_data.rem_x - trial[NUM_W-1:0];
                data_next.q_x[J] = 1'b1;
            end
            if ({1'b0, in_data.rem_y} >= trial) begin
                data_next.rem_y  = in_data.rem_y - trial[NUM_W-1:0];
                data_next.q_y[J] = 1'b1;
            end
        end
        if (ROT_ON) begin
            if (!in_data.az[ANG_W-1]) begin
                data_next.ax = in_data.ax - (in_data.ay >>> IDX);
                data_next.ay = in_data.ay + (in_data.ax >>> IDX);
                data_next.az = in_data.az - ATAN;
            end else begin
                data_next.ax = in_data.ax + (in_data.ay >>> IDX);
                data_next.ay = in_data.ay - (in_data.ax >>> IDX);
                data_next.az = in_data.az + ATAN;
            end
            if (!in_data.bz[ANG_W-1]) begin
                data_next.bx = in_data.bx - (in_data.by >>> IDX);
                data_next.by = in_data.by + (in_data.bx >>> IDX);
                data_next.bz = in_data.bz - ATAN;
            end else begin
                data_next.bx = in_data.bx + (in_data.by >>> IDX);
                data_next.by = in_data.by - (in_data.bx >>> IDX);
                data_next.bz = in_data.bz + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/camera_ray_direction_core.sv -----
// Camera ray direction core.
// Input channel s_*: one screen point (point_x, point_y, signed Q4.12) per request.
// Output channel m_*: one direction (dir_x, dir_y, dir_z, signed Q16.16) per request,
// in request order. Config port: cfg_wr_en/cfg_index/cfg_wr_data, write only while idle;
// indexes 0 mode, 1 field of view, 2..4 rotation rows; other indexes are ignored.
// Throughput: one request per cycle, sustained while the receiver does not stall.
// Pipeline: the front-end stages, the 26 square-root cells and the row of divide/CORDIC
// cells (each gives at most one quotient bit and one rotation), then the combine and
// matrix stages.
// The whole pipeline advances only while the output register is empty or taken;
// when the receiver stalls, s_ready drops and every in-flight request holds.
// Reset clears all valid flags and loads mode 3 (perspective), a field of view
// of 1.0 and the identity rotation.
module camera_ray_direction_core
    import crd_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [PT_W-1:0]  s_point_x,
    input  logic signed [PT_W-1:0]  s_point_y,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DIR_W-1:0] m_dir_x,
    output logic signed [DIR_W-1:0] m_dir_y,
    output logic signed [DIR_W-1:0] m_dir_z,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ROW_W-1:0]        cfg_wr_data
);

    localparam int CELLS = (CORDIC_STAGES > DIV_BITS) ? CORDIC_STAGES : DIV_BITS;

    logic [MODE_W-1:0] mode_reg;
    logic [FOV_W-1:0]  fov_reg;
    logic [ROW_W-1:0]  rot_reg [3];

    logic adv;
    logic fish;

    // front end
    logic                   p_valid_reg;
    logic signed [PT_W-1:0] p_px_reg, p_py_reg;
    logic                   q_valid_reg;
    logic signed [PT_W-1:0] q_px_reg, q_py_reg;
    logic signed [31:0]     q_sqx_reg, q_sqy_reg;
    logic [31:0]            sum_sq;

    sq_t  sq_data  [SQ_STEPS+1];
    logic sq_valid [SQ_STEPS+1];

    logic                    t_valid_reg;
    logic [MAG_W-1:0]        t_mag_reg;
    logic [MAG_W+FOV_W-1:0]  t_prod_reg;
    logic signed [PT_W:0]    fov_s;
    logic signed [2*PT_W:0]  t_pa_reg, t_pb_reg;
    logic signed [PT_W-1:0]  t_px_reg, t_py_reg;

    logic [31:0]      theta, ang_a_raw, ang_b_raw, wrap_a, wrap_b, ang_a, ang_b;
    logic [PT_W-1:0]  abs_x, abs_y;
    core_t            core_init;

    core_t core_data  [CELLS+1];
    logic  core_valid [CELLS+1];

    // combine
    core_t                   c;
    logic signed [VEC_W-1:0] ca, sa, cb, sb;
    logic signed [31:0]      cphi, sphi;
    logic signed [65:0]      p_fx, p_fy, p_sc, p_cc;
    logic signed [2*PT_W:0]  p_px, p_py;
    logic signed [V_W-1:0]   v_next [3];
    logic                    v_valid_reg;
    logic signed [V_W-1:0]   v_reg [3];

    logic                     mp_valid_reg;
    logic signed [PROD_W-1:0] mp_reg [3][3];
    logic                     acc_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic                     m_valid_reg;
    logic signed [DIR_W-1:0]  dir_reg [3];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign fish    = (mode_reg == MODE_FISHEYE) || (mode_reg == MODE_FISHEYE_CUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_PERSPECTIVE;
            fov_reg    <= FOV_RESET;
            rot_reg[0] <= ROW0_RESET;
            rot_reg[1] <= ROW1_RESET;
            rot_reg[2] <= ROW2_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE: mode_reg   <= cfg_wr_data[MODE_W-1:0];
                REG_FOV:  fov_reg    <= cfg_wr_data[FOV_W-1:0];
                REG_ROW0: rot_reg[0] <= cfg_wr_data;
                REG_ROW1: rot_reg[1] <= cfg_wr_data;
                REG_ROW2: rot_reg[2] <= cfg_wr_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            sq_valid[0]   <= 1'b0;
            t_valid_reg   <= 1'b0;
            core_valid[0] <= 1'b0;
            v_valid_reg   <= 1'b0;
            mp_valid_reg  <= 1'b0;
            acc_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (adv) begin
            p_valid_reg   <= s_valid;
            q_valid_reg   <= p_valid_reg;
            sq_valid[0]   <= q_valid_reg;
            t_valid_reg   <= sq_valid[SQ_STEPS];
            core_valid[0] <= t_valid_reg;
            v_valid_reg   <= core_valid[CELLS];
            mp_valid_reg  <= v_valid_reg;
            acc_valid_reg <= mp_valid_reg;
            m_valid_reg   <= acc_valid_reg;
        end
    end

    assign sum_sq = $unsigned(q_sqx_reg) + $unsigned(q_sqy_reg);
    assign fov_s  = $signed({1'b0, fov_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_px_reg <= s_point_x;
            p_py_reg <= s_point_y;

            q_px_reg  <= p_px_reg;
            q_py_reg  <= p_py_reg;
            q_sqx_reg <= p_px_reg * p_px_reg;
            q_sqy_reg <= p_py_reg * p_py_reg;

            sq_data[0].rem  <= {sum_sq, 20'b0};
            sq_data[0].root <= '0;
            sq_data[0].px   <= q_px_reg;
            sq_data[0].py   <= q_py_reg;

            t_mag_reg  <= sq_data[SQ_STEPS].root[MAG_W-1:0];
            t_prod_reg <= sq_data[SQ_STEPS].root[MAG_W-1:0] * fov_reg;
            t_pa_reg   <= sq_data[SQ_STEPS].px * fov_s;
            t_pb_reg   <= sq_data[SQ_STEPS].py * fov_s;
            t_px_reg   <= sq_data[SQ_STEPS].px;
            t_py_reg   <= sq_data[SQ_STEPS].py;

            core_data[0] <= core_init;
        end
    end

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        crd_sqrt_cell #(
            .STEP(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (sq_valid[i]),
            .in_data  (sq_data[i]),
            .out_valid(sq_valid[i+1]),
            .out_data (sq_data[i+1])
        );
    end

    always_comb begin
        theta     = t_prod_reg[34:3];
        ang_a_raw = fish ? theta : {t_pa_reg[24:0], 7'b0};
        ang_b_raw = {t_pb_reg[24:0], 7'b0};
        wrap_a    = ang_a_raw + QUARTER_TURN;
        wrap_b    = ang_b_raw + QUARTER_TURN;
        ang_a     = wrap_a[31] ? ang_a_raw + HALF_TURN : ang_a_raw;
        ang_b     = wrap_b[31] ? ang_b_raw + HALF_TURN : ang_b_raw;
        abs_x     = t_px_reg[PT_W-1] ? ~$unsigned(t_px_reg) + 16'd1 : $unsigned(t_px_reg);
        abs_y     = t_py_reg[PT_W-1] ? ~$unsigned(t_py_reg) + 16'd1 : $unsigned(t_py_reg);

        core_init.rem_x  = {abs_x, 40'b0};
        core_init.rem_y  = {abs_y, 40'b0};
        core_init.q_x    = '0;
        core_init.q_y    = '0;
        core_init.den    = t_mag_reg;
        core_init.neg_x  = t_px_reg[PT_W-1];
        core_init.neg_y  = t_py_reg[PT_W-1];
        core_init.zero   = (t_px_reg == '0) && (t_py_reg == '0);
        core_init.ax     = CORDIC_GAIN;
        core_init.ay     = '0;
        core_init.az     = $signed({{2{ang_a[31]}}, ang_a});
        core_init.bx     = CORDIC_GAIN;
        core_init.by     = '0;
        core_init.bz     = $signed({{2{ang_b[31]}}, ang_b});
        core_init.flip_a = wrap_a[31];
        core_init.flip_b = wrap_b[31];
        core_init.px     = t_px_reg;
        core_init.py     = t_py_reg;
    end

    for (genvar i = 0; i < CELLS; i++) begin : g_core
        crd_core_cell #(
            .IDX   (i),
            .STAGES(CORDIC_STAGES)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (core_valid[i]),
            .in_data  (core_data[i]),
            .out_valid(core_valid[i+1]),
            .out_data (core_data[i+1])
        );
    end

    always_comb begin
        c    = core_data[CELLS];
        ca   = c.flip_a ? -c.ax : c.ax;
        sa   = c.flip_a ? -c.ay : c.ay;
        cb   = c.flip_b ? -c.bx : c.bx;
        sb   = c.flip_b ? -c.by : c.by;
        cphi = c.neg_x ? -$signed({1'b0, c.q_x}) : $signed({1'b0, c.q_x});
        sphi = c.neg_y ? -$signed({1'b0, c.q_y}) : $signed({1'b0, c.q_y});
        p_fx = cphi * sa;
        p_fy = sphi * sa;
        p_sc = sa * cb;
        p_cc = ca * cb;
        p_px = c.px * fov_s;
        p_py = c.py * fov_s;
        case (mode_reg)
            MODE_FISHEYE, MODE_FISHEYE_CUT: begin
                if (c.zero) begin
                    v_next[0] = '0;
                    v_next[1] = ONE_V;
                    v_next[2] = '0;
                end else begin
                    v_next[0] = V_W'(p_fx >>> 30);
                    v_next[1] = V_W'(ca);
                    v_next[2] = V_W'(p_fy >>> 30);
                end
            end
            MODE_EQUIRECT: begin
                v_next[0] = V_W'(p_sc >>> 30);
                v_next[1] = V_W'(p_cc >>> 30);
                v_next[2] = V_W'(sb);
            end
            MODE_PERSPECTIVE: begin
                v_next[0] = V_W'(p_px) <<< 6;
                v_next[1] = ONE_V;
                v_next[2] = V_W'(p_py) <<< 6;
            end
            default: begin
                v_next[0] = V_W'(p_px) <<< 6;
                v_next[1] = ONE_V;
                v_next[2] = V_W'(p_py) <<< 6;
            end
        endcase
    end

    // sum of three Q2.14 x vector terms stays well inside 32 bits after the shift
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                v_reg[r] <= v_next[r];
                for (int k = 0; k < 3; k++) begin
                    mp_reg[r][k] <= $signed(rot_reg[r][COEF_W*k +: COEF_W]) * v_reg[k];
                end
                acc_reg[r] <= ACC_W'(mp_reg[r][0]) + ACC_W'(mp_reg[r][1])
                            + ACC_W'(mp_reg[r][2]);
                dir_reg[r] <= DIR_W'(acc_reg[r] >>> ACC_SHIFT);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_dir_x = dir_reg[0];
    assign m_dir_y = dir_reg[1];
    assign m_dir_z = dir_reg[2];

endmodule

// ----- sim/camera_ray_direction_core_tb.sv -----
`timescale 1ns / 1ps

module camera_ray_direction_core_tb;
    import crd_pkg::*;

    localparam int LATENCY = 35 + 31;
    localparam int CYCLE_LIMIT = 400000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [PT_W-1:0]  s_point_x;
    logic signed [PT_W-1:0]  s_point_y;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [DIR_W-1:0] m_dir_x;
    logic signed [DIR_W-1:0] m_dir_y;
    logic signed [DIR_W-1:0] m_dir_z;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [ROW_W-1:0]        cfg_wr_data;

    camera_ray_direction_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dir_x     (m_dir_x),
        .m_dir_y     (m_dir_y),
        .m_dir_z     (m_dir_z),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    typedef struct {
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
    } ray_t;

    class ray_scoreboard;
        logic [MODE_W-1:0] mode;
        logic [FOV_W-1:0]  fov;
        logic [ROW_W-1:0]  rows[3];
        ray_t              pending[$];
        int                mismatches;

        function new();
            mode = MODE_PERSPECTIVE;
            fov = FOV_RESET;
            rows[0] = ROW0_RESET;
            rows[1] = ROW1_RESET;
            rows[2] = ROW2_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
            case (idx)
                REG_MODE: mode = val[MODE_W-1:0];
                REG_FOV:  fov = val[FOV_W-1:0];
                REG_ROW0: rows[0] = val;
                REG_ROW1: rows[1] = val;
                REG_ROW2: rows[2] = val;
                default: ;
            endcase
        endfunction

        static function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint int_sqrt(longint unsigned n);
            longint unsigned res, bit_v;
            res = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > n) bit_v >>= 2;
            while (bit_v != 0) begin
                if (n >= res + bit_v) begin
                    n -= res + bit_v;
                    res = (res >> 1) + bit_v;
                end else begin
                    res >>= 1;
                end
                bit_v >>= 2;
            end
            return res;
        endfunction

        static function void rotate_turns(logic [31:0] ang, output longint c,
                                          output longint s);
            bit     flip;
            longint x, y, z, nx;
            flip = 0;
            x = 652032874;
            y = 0;
            if (((ang + QUARTER_TURN) & HALF_TURN) != 0) begin
                flip = 1;
                ang = ang + HALF_TURN;
            end
            z = longint'(ang) - (ang[31] ? (64'sd1 <<< 32) : 64'sd0);
            for (int i = 0; i < CORDIC_STAGES_DEFAULT && i < 32; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= longint'(atan_turn(i));
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += longint'(atan_turn(i));
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = x;
            s = y;
        endfunction

        function ray_t trace_ray(logic signed [PT_W-1:0] px_in, logic signed [PT_W-1:0] py_in);
            longint px, py, f, v[3], acc, cphi, sphi, ct, st, ca, sa, cb, sb;
            longint unsigned mag;
            logic [31:0] th, a, b;
            longint outv[3];
            ray_t r;
            px = px_in;
            py = py_in;
            f = fov;
            if (mode == MODE_FISHEYE || mode == MODE_FISHEYE_CUT) begin
                if (px == 0 && py == 0) begin
                    v[0] = 0;
                    v[1] = 64'sd1 <<< 30;
                    v[2] = 0;
                end else begin
                    mag = int_sqrt(longint'(px * px + py * py) << 20);
                    cphi = (px * (64'sd1 <<< 40)) / longint'(mag);
                    sphi = (py * (64'sd1 <<< 40)) / longint'(mag);
                    th = 32'((mag * longint'(f)) >> 3);
                    rotate_turns(th, ct, st);
                    v[0] = floor_shift(cphi * st, 30);
                    v[1] = ct;
                    v[2] = floor_shift(sphi * st, 30);
                end
            end else if (mode == MODE_EQUIRECT) begin
                a = 32'((px * f) << 7);
                b = 32'((py * f) << 7);
                rotate_turns(a, ca, sa);
                rotate_turns(b, cb, sb);
                v[0] = floor_shift(sa * cb, 30);
                v[1] = floor_shift(ca * cb, 30);
                v[2] = sb;
            end else begin
                v[0] = px * f * 64;
                v[1] = 64'sd1 <<< 30;
                v[2] = py * f * 64;
            end
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += longint'($signed(rows[i][16*k +: 16])) * v[k];
                acc = floor_shift(acc, ACC_SHIFT);
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                outv[i] = acc;
            end
            r.dx = outv[0][31:0];
            r.dy = outv[1][31:0];
            r.dz = outv[2][31:0];
            return r;
        endfunction

        function void note_point(logic signed [PT_W-1:0] px, logic signed [PT_W-1:0] py);
            pending.push_back(trace_ray(px, py));
        endfunction

        function void check_ray(ray_t got);
            ray_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d %0d %0d", got.dx, got.dy, got.dz);
                return;
            end
            want = pending.pop_front();
            if (got.dx !== want.dx || got.dy !== want.dy || got.dz !== want.dz) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch mode %0d: exp %0d %0d %0d got %0d %0d %0d",
                             mode, want.dx, want.dy, want.dz, got.dx, got.dy, got.dz);
            end
        endfunction
    endclass

    ray_scoreboard sb;
    int            cycles = 0;
    int            stall_mode = 0;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall pattern, mode changes every so often
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(3) != 0);
                2: m_ready <= ($urandom_range(3) == 0);
                default: m_ready <= cycles[2];
            endcase
            if ($urandom_range(199) == 0) stall_mode <= $urandom_range(3);
        end
    end

    always @(posedge aclk) begin
        ray_t got;
        if (aresetn && m_valid && m_ready) begin
            got.dx = m_dir_x;
            got.dy = m_dir_y;
            got.dz = m_dir_z;
            sb.check_ray(got);
        end
    end

    task automatic send_point(logic signed [PT_W-1:0] px, logic signed [PT_W-1:0] py);
        s_valid <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_point(px, py);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [ROW_W-1:0] pack_row(logic [15:0] c0, logic [15:0] c1,
                                                  logic [15:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic logic [15:0] rand_pt(int spread);
        case (spread)
            0: return 16'($urandom_range(8191)) - 16'd4096;
            1: return 16'($urandom);
            default: return 16'($urandom_range(1)) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic directed_block();
        send_point(16'sd0, 16'sd0);
        send_point(16'sh7fff, 16'sh7fff);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sh7fff, -16'sd32768);
        send_point(16'sd4096, 16'sd0);
        send_point(16'sd0, -16'sd4096);
        send_point(16'sd1, 16'sd0);
        send_point(-16'sd1, 16'sd1);
    endtask

    task automatic random_phase(int count);
        int spread;
        for (int i = 0; i < count; i++) begin
            spread = $urandom_range(9) < 7 ? 0 : ($urandom_range(4) == 0 ? 2 : 1);
            send_point(rand_pt(spread), rand_pt(spread));
            if ($urandom_range(7) == 0) idle_gap($urandom_range(6));
        end
    endtask

    initial begin
        logic [15:0] fov_vals[6];
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_point_x <= '0;
        s_point_y <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wr_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        fov_vals = '{16'd4096, 16'd0, 16'hffff, 16'd2048, 16'd1, 16'd12000};
        // reset config first, then each mode at several fov and matrices
        directed_block();
        random_phase(20);
        drain();
        for (int p = 0; p < 12; p++) begin
            write_cfg(REG_MODE, ROW_W'(p % 4));
            write_cfg(REG_FOV, ROW_W'(p < 6 ? fov_vals[p] : 16'($urandom)));
            if (p == 3) begin
                write_cfg(REG_ROW0, pack_row(16'h7fff, 16'h7fff, 16'h7fff));
                write_cfg(REG_ROW1, pack_row(16'h8000, 16'h8000, 16'h8000));
                write_cfg(REG_ROW2, pack_row(16'h7fff, 16'h8000, 16'h0000));
            end else if (p > 3) begin
                write_cfg(REG_ROW0, ROW_W'({$urandom, $urandom}));
                write_cfg(REG_ROW1, ROW_W'({$urandom, $urandom}));
                write_cfg(REG_ROW2, ROW_W'({$urandom, $urandom}));
            end
            if (p == 8) begin
                write_cfg(REG_ROW0, ROW0_RESET);
                write_cfg(REG_ROW1, ROW1_RESET);
                write_cfg(REG_ROW2, ROW2_RESET);
            end
            if (p < 4) directed_block();
            random_phase(80);
            drain();
        end

        drain();
        repeat (LATENCY) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- camera_ray_direction_core.f -----
hdl/crd_pkg.sv
hdl/crd_sqrt_cell.sv
hdl/crd_core_cell.sv
hdl/camera_ray_direction_core.sv
sim/camera_ray_direction_core_tb.sv
